// ===== hw/rtl/ign_pkg.sv =====
package ign_pkg;

   // Number formats.
   localparam int FRAC_BITS = 16;
   localparam int TABLE_SIZE = 256;
   localparam int TBL_AW = $clog2(TABLE_SIZE);
   localparam int TBL_DW = 8;
   localparam int COORD_W = 32;
   localparam int OUT_W = 17;

   // Packed channel widths.
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 24;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // Number of table copies that serve the hash reads of one item per cycle while the pipeline moves.
   localparam int RAM_COPIES = 7;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_SAMPLE = 1'b1
   } opcode_type;

   // One classified item as it sits in the queue.
   typedef struct packed {
      opcode_type             op;
      logic [TBL_DW-1:0]      tbl_idx;
      logic [TBL_DW-1:0]      tbl_val;
      logic [TBL_AW-1:0]      cell_x;
      logic [TBL_AW-1:0]      cell_y;
      logic [TBL_AW-1:0]      cell_z;
      logic [FRAC_BITS-1:0]   frac_x;
      logic [FRAC_BITS-1:0]   frac_y;
      logic [FRAC_BITS-1:0]   frac_z;
   } cmd_type;

   // Status of the back end, seen by the top level.
   typedef struct packed {
      logic load_take;
      logic s1_busy;
   } bk_stat_type;

endpackage

// ===== hw/rtl/ign_front.sv =====
module ign_front (
   input  logic                               req_tuser,
   input  logic [ign_pkg::REQ_DATA_W-1:0]     req_tdata,
   output ign_pkg::cmd_type                   cmd
);

   logic [ign_pkg::COORD_W-1:0] coord_x;
   logic [ign_pkg::COORD_W-1:0] coord_y;
   logic [ign_pkg::COORD_W-1:0] coord_z;

   // Unpack the coordinates.
   assign coord_x = req_tdata[2*ign_pkg::TBL_DW +: ign_pkg::COORD_W];
   assign coord_y = req_tdata[2*ign_pkg::TBL_DW + ign_pkg::COORD_W +: ign_pkg::COORD_W];
   assign coord_z = req_tdata[2*ign_pkg::TBL_DW + 2*ign_pkg::COORD_W +: ign_pkg::COORD_W];

   // Classify the item and split each coordinate into lattice cell and fraction.
   // The cell is floor(coordinate) taken modulo the table size.
   always_comb begin
      cmd.op      = req_tuser ? ign_pkg::OP_SAMPLE : ign_pkg::OP_LOAD;
      cmd.tbl_idx = req_tdata[0 +: ign_pkg::TBL_DW];
      cmd.tbl_val = req_tdata[ign_pkg::TBL_DW +: ign_pkg::TBL_DW];
      cmd.cell_x  = coord_x[ign_pkg::FRAC_BITS +: ign_pkg::TBL_AW];
      cmd.cell_y  = coord_y[ign_pkg::FRAC_BITS +: ign_pkg::TBL_AW];
      cmd.cell_z  = coord_z[ign_pkg::FRAC_BITS +: ign_pkg::TBL_AW];
      cmd.frac_x  = coord_x[ign_pkg::FRAC_BITS-1:0];
      cmd.frac_y  = coord_y[ign_pkg::FRAC_BITS-1:0];
      cmd.frac_z  = coord_z[ign_pkg::FRAC_BITS-1:0];
   end

endmodule

// ===== hw/rtl/ign_fifo.sv =====
module ign_fifo (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  ign_pkg::cmd_type               push_data,
   output logic                           full,
   input  logic                           pop,
   output logic                           head_valid,
   output ign_pkg::cmd_type               head,
   output logic [ign_pkg::QCNT_W-1:0]     count
);

   ign_pkg::cmd_type              mem_ff [ign_pkg::QUEUE_DEPTH];
   logic [ign_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [ign_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [ign_pkg::QCNT_W-1:0]    count_ff, count_in;

   assign full       = (count_ff == ign_pkg::QCNT_W'(ign_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign count      = count_ff;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/ign_ram.sv =====
module ign_ram (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [ign_pkg::TBL_AW-1:0]     wr_addr,
   input  logic [ign_pkg::TBL_DW-1:0]     wr_data,
   input  logic                           rd_en,
   input  logic [ign_pkg::TBL_AW-1:0]     rd_addr_a,
   input  logic [ign_pkg::TBL_AW-1:0]     rd_addr_b,
   input  logic                           rd_valid_a,
   input  logic                           rd_valid_b,
   output logic [ign_pkg::TBL_DW-1:0]     rd_data_a,
   output logic [ign_pkg::TBL_DW-1:0]     rd_data_b
);

   logic [ign_pkg::TBL_DW-1:0]      mem [ign_pkg::TABLE_SIZE];
   logic [ign_pkg::TBL_DW-1:0]      rd_data_a_ff;
   logic [ign_pkg::TBL_DW-1:0]      rd_data_b_ff;

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read ports, held while the pipeline stalls.
   // An entry that was never written reads as its own index.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= rd_valid_a ? mem[rd_addr_a] : ign_pkg::TBL_DW'(rd_addr_a);
         rd_data_b_ff <= rd_valid_b ? mem[rd_addr_b] : ign_pkg::TBL_DW'(rd_addr_b);
      end
   end

endmodule

// ===== hw/rtl/ign_back.sv =====
module ign_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              head_valid,
   input  ign_pkg::cmd_type                  head,
   output logic                              take,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [ign_pkg::OUT_W-1:0]         rsp_noise,
   output ign_pkg::bk_stat_type              stat
);

   localparam int FB = ign_pkg::FRAC_BITS;
   localparam int AW = ign_pkg::TBL_AW;
   localparam int DW = ign_pkg::TBL_DW;
   localparam int TW = FB + 1;          // fraction or fraction minus one
   localparam int GW = FB + 3;          // gradient dot product
   localparam int LW = FB + 8;          // interpolated values
   localparam int PW = 48;              // product width
   localparam int FW = FB + 2;          // fade output
   localparam int MW = FB + 6;          // fade polynomial
   localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FB - 1);
   localparam logic signed [MW+1:0] ONE_M = (MW+2)'(1) <<< FB;
   localparam logic signed [MW+1:0] SIX = (MW+2)'(6);
   localparam logic signed [MW-1:0] TEN_ONE = MW'(10) <<< FB;
   localparam logic signed [TW-1:0] ONE_T = TW'(1) <<< FB;
   localparam logic signed [LW:0] ONE_L = (LW+1)'(1) <<< FB;
   localparam int OUT_SHIFT = FB - 15;
   localparam logic signed [LW:0] OUT_HALF = (LW+1)'(1) <<< (OUT_SHIFT - 1);
   localparam logic signed [LW:0] OUT_MAX = (LW+1)'(65536);

   // Multiply-product rounding: floor(p + half) in fraction units.
   function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] p);
      rnd = (p + HALF) >>> FB;
   endfunction

   // One interpolation step a + t*(b - a).
   function automatic logic signed [LW-1:0] lerp(input logic signed [FW-1:0] t,
                                                 input logic signed [LW-1:0] a,
                                                 input logic signed [LW-1:0] b);
      logic signed [LW:0]   d;
      logic signed [PW-1:0] p;
      d = (LW+1)'(b) - (LW+1)'(a);
      p = PW'(t) * PW'(d);
      p = rnd(p);
      lerp = a + p[LW-1:0];
   endfunction

   // Dot product with one of the cube's edge gradients, chosen by the hash bits h.
   function automatic logic signed [GW-1:0] grad(input logic [3:0] h,
                                                 input logic signed [TW-1:0] x,
                                                 input logic signed [TW-1:0] y,
                                                 input logic signed [TW-1:0] z);
      logic signed [GW-1:0] gu;
      logic signed [GW-1:0] gv;
      gu = (h < 4'd8) ? GW'(x) : GW'(y);
      if (h < 4'd4) begin
         gv = GW'(y);
      end else if (h == 4'd12 || h == 4'd14) begin
         gv = GW'(x);
      end else begin
         gv = GW'(z);
      end
      grad = (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
   endfunction

   logic en;
   logic wr_en;

   // Written flags shared by all table copies.
   logic [ign_pkg::TABLE_SIZE-1:0] tbl_valid_ff;

   // Table copy ports.
   logic [AW-1:0] rd_a [ign_pkg::RAM_COPIES];
   logic [AW-1:0] rd_b [ign_pkg::RAM_COPIES];
   logic [DW-1:0] q_a  [ign_pkg::RAM_COPIES];
   logic [DW-1:0] q_b  [ign_pkg::RAM_COPIES];

   // Stage registers.
   logic                    s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic                    s5_valid_ff, s6_valid_ff, s7_valid_ff, rsp_valid_ff;
   logic [AW-1:0]           s1_y_ff, s1_z_ff, s2_z_ff;
   logic [FB-1:0]           s1_f_ff [3];
   logic [FB-1:0]           s2_f_ff [3];
   logic [FB-1:0]           s3_f_ff [3];
   logic signed [TW-1:0]    s1_t2_ff [3];
   logic signed [MW-1:0]    s1_pm_ff [3];
   logic signed [TW-1:0]    s2_t3_ff [3];
   logic signed [MW-1:0]    s2_pm_ff [3];
   logic signed [FW-1:0]    s3_fade_ff [3];
   logic signed [FW-1:0]    s4_fade_ff [3];
   logic signed [FW-1:0]    s5_fade_ff [3];
   logic signed [FW-1:0]    s6_w_ff;
   logic signed [GW-1:0]    s4_g_ff [8];
   logic signed [LW-1:0]    s5_l_ff [4];
   logic signed [LW-1:0]    s6_l_ff [2];
   logic signed [LW-1:0]    s7_res_ff;
   logic [ign_pkg::OUT_W-1:0] rsp_noise_ff, rsp_noise_in;

   // Combinational values between stages.
   logic [FB-1:0]           s0_f [3];
   logic signed [TW-1:0]    t0 [3];
   logic signed [TW-1:0]    t1 [3];
   logic signed [TW-1:0]    t2 [3];
   logic signed [MW+1:0]    lin [3];
   logic signed [PW-1:0]    p_tt [3];
   logic signed [PW-1:0]    p_tl [3];
   logic signed [PW-1:0]    p_t3 [3];
   logic signed [PW-1:0]    p_fd [3];
   logic [AW-1:0]           aa, ab, ba, bb, a_h, b_h;
   logic signed [TW-1:0]    cx0, cy0, cz0, cx1, cy1, cz1;
   logic signed [GW-1:0]    g_in [8];
   logic signed [LW:0]      out_s;
   logic signed [LW:0]      out_q;

   // The whole pipeline moves when the output register is free or being taken.
   assign en    = !rsp_valid_ff || rsp_tready;
   // A load waits until no sample sits between the first and second table reads,
   // so that every sample sees the table as it was when the sample arrived.
   assign take  = head_valid && en && (head.op == ign_pkg::OP_SAMPLE || !s1_valid_ff);
   assign wr_en = take && head.op == ign_pkg::OP_LOAD
                  && ({1'b0, head.tbl_idx} < (DW+1)'(ign_pkg::TABLE_SIZE));

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_noise  = rsp_noise_ff;
   assign stat.load_take = take && head.op == ign_pkg::OP_LOAD;
   assign stat.s1_busy   = s1_valid_ff;

   // An entry that was never written reads as its own index.
   always_ff @(posedge clock) begin
      if (reset) begin
         tbl_valid_ff <= '0;
      end else if (wr_en) begin
         tbl_valid_ff[head.tbl_idx[AW-1:0]] <= 1'b1;
      end
   end

   // Hash address generation for the three levels of table reads.
   assign a_h = q_a[0] + s1_y_ff;
   assign b_h = q_b[0] + s1_y_ff;
   assign aa  = q_a[1] + s2_z_ff;
   assign ab  = q_b[1] + s2_z_ff;
   assign ba  = q_a[2] + s2_z_ff;
   assign bb  = q_b[2] + s2_z_ff;

   always_comb begin
      rd_a[0] = head.cell_x;
      rd_b[0] = head.cell_x + 1'b1;
      rd_a[1] = a_h;
      rd_b[1] = a_h + 1'b1;
      rd_a[2] = b_h;
      rd_b[2] = b_h + 1'b1;
      rd_a[3] = aa;
      rd_b[3] = aa + 1'b1;
      rd_a[4] = ba;
      rd_b[4] = ba + 1'b1;
      rd_a[5] = ab;
      rd_b[5] = ab + 1'b1;
      rd_a[6] = bb;
      rd_b[6] = bb + 1'b1;
   end

   // Table copies, all written together by a load item.
   for (genvar i = 0; i < ign_pkg::RAM_COPIES; i++) begin : g_tbl
      ign_ram u_ram (
         .clock      (clock),
         .wr_en      (wr_en),
         .wr_addr    (head.tbl_idx[AW-1:0]),
         .wr_data    (head.tbl_val),
         .rd_en      (en),
         .rd_addr_a  (rd_a[i]),
         .rd_addr_b  (rd_b[i]),
         .rd_valid_a (tbl_valid_ff[rd_a[i]]),
         .rd_valid_b (tbl_valid_ff[rd_b[i]]),
         .rd_data_a  (q_a[i]),
         .rd_data_b  (q_b[i])
      );
   end

   // Fade polynomial over three stages: two multipliers per axis in the first, one in each of the others.
   always_comb begin
      s0_f[0] = head.frac_x;
      s0_f[1] = head.frac_y;
      s0_f[2] = head.frac_z;
      for (int i = 0; i < 3; i++) begin
         t0[i]   = signed'({1'b0, s0_f[i]});
         lin[i]  = (MW+2)'(t0[i]) * SIX - (ONE_M * (MW+2)'(15));
         p_tt[i] = rnd(PW'(t0[i]) * PW'(t0[i]));
         p_tl[i] = rnd(PW'(t0[i]) * PW'(lin[i]));
         t1[i]   = signed'({1'b0, s1_f_ff[i]});
         p_t3[i] = rnd(PW'(s1_t2_ff[i]) * PW'(t1[i]));
         p_fd[i] = rnd(PW'(s2_t3_ff[i]) * PW'(s2_pm_ff[i]));
         t2[i]   = signed'({1'b0, s3_f_ff[i]});
      end
   end

   // Gradients of the eight cell corners.
   assign cx0 = t2[0];
   assign cy0 = t2[1];
   assign cz0 = t2[2];
   assign cx1 = t2[0] - ONE_T;
   assign cy1 = t2[1] - ONE_T;
   assign cz1 = t2[2] - ONE_T;

   always_comb begin
      g_in[0] = grad(q_a[3][3:0], cx0, cy0, cz0);
      g_in[1] = grad(q_a[4][3:0], cx1, cy0, cz0);
      g_in[2] = grad(q_a[5][3:0], cx0, cy1, cz0);
      g_in[3] = grad(q_a[6][3:0], cx1, cy1, cz0);
      g_in[4] = grad(q_b[3][3:0], cx0, cy0, cz1);
      g_in[5] = grad(q_b[4][3:0], cx1, cy0, cz1);
      g_in[6] = grad(q_b[5][3:0], cx0, cy1, cz1);
      g_in[7] = grad(q_b[6][3:0], cx1, cy1, cz1);
   end

   // Map (res + 1) / 2 onto 16 fraction bits with saturation.
   always_comb begin
      out_s = (LW+1)'(s7_res_ff) + ONE_L;
      out_q = (out_s + OUT_HALF) >>> OUT_SHIFT;
      if (out_s <= 0) begin
         rsp_noise_in = '0;
      end else if (out_q > OUT_MAX) begin
         rsp_noise_in = ign_pkg::OUT_W'(OUT_MAX);
      end else begin
         rsp_noise_in = out_q[ign_pkg::OUT_W-1:0];
      end
   end

   // Valid bits of the stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= take && head.op == ign_pkg::OP_SAMPLE;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         s7_valid_ff  <= s6_valid_ff;
         rsp_valid_ff <= s7_valid_ff;
      end
   end

   // Payload of the stages.
   always_ff @(posedge clock) begin
      if (en) begin
         s1_y_ff <= head.cell_y;
         s1_z_ff <= head.cell_z;
         s2_z_ff <= s1_z_ff;
         for (int i = 0; i < 3; i++) begin
            s1_f_ff[i]    <= s0_f[i];
            s1_t2_ff[i]   <= p_tt[i][TW-1:0];
            s1_pm_ff[i]   <= p_tl[i][MW-1:0] + TEN_ONE;
            s2_f_ff[i]    <= s1_f_ff[i];
            s2_t3_ff[i]   <= p_t3[i][TW-1:0];
            s2_pm_ff[i]   <= s1_pm_ff[i];
            s3_f_ff[i]    <= s2_f_ff[i];
            s3_fade_ff[i] <= p_fd[i][FW-1:0];
            s4_fade_ff[i] <= s3_fade_ff[i];
            s5_fade_ff[i] <= s4_fade_ff[i];
         end
         for (int i = 0; i < 8; i++) begin
            s4_g_ff[i] <= g_in[i];
         end
         s5_l_ff[0]   <= lerp(s4_fade_ff[0], LW'(s4_g_ff[0]), LW'(s4_g_ff[1]));
         s5_l_ff[1]   <= lerp(s4_fade_ff[0], LW'(s4_g_ff[2]), LW'(s4_g_ff[3]));
         s5_l_ff[2]   <= lerp(s4_fade_ff[0], LW'(s4_g_ff[4]), LW'(s4_g_ff[5]));
         s5_l_ff[3]   <= lerp(s4_fade_ff[0], LW'(s4_g_ff[6]), LW'(s4_g_ff[7]));
         s6_l_ff[0]   <= lerp(s5_fade_ff[1], s5_l_ff[0], s5_l_ff[1]);
         s6_l_ff[1]   <= lerp(s5_fade_ff[1], s5_l_ff[2], s5_l_ff[3]);
         s6_w_ff      <= s5_fade_ff[2];
         s7_res_ff    <= lerp(s6_w_ff, s6_l_ff[0], s6_l_ff[1]);
         rsp_noise_ff <= rsp_noise_in;
      end
   end

endmodule

// ===== hw/rtl/improved_gradient_noise_3d.sv =====
// Channel   Direction  Handshake              Contents
// req       in         req_tvalid/req_tready  tuser: opcode; tdata: index, value, x, y, z
// rsp       out        rsp_tvalid/rsp_tready  tdata: noise_value
//
// A sample passes from the queue head to the output register through three levels
// of table reads, one grid of gradients and three interpolation stages; one new item
// enters the pipeline per cycle while the output is not stalled and no load is held back.
// A load item waits at the queue head while a sample sits in the first stage, just
// after its first table read. Reset is synchronous; it empties the queue and the
// pipeline and returns the table to identity. A stalled output freezes the
// pipeline while the queue keeps taking items until it holds four.
module improved_gradient_noise_3d (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // Bit 0: opcode.
   input  logic                               req_tuser,
   // From bit 0: table_index[7:0], table_value[7:0], coord_x[31:0], coord_y[31:0],
   // coord_z[31:0].
   input  logic [ign_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // From bit 0: noise_value[16:0], then zero fill.
   output logic [ign_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   ign_pkg::cmd_type              cmd;
   ign_pkg::cmd_type              head;
   ign_pkg::bk_stat_type          stat;
   logic                          q_full;
   logic                          q_push;
   logic                          q_pop;
   logic                          head_valid;
   logic [ign_pkg::QCNT_W-1:0]    q_count;
   logic [ign_pkg::OUT_W-1:0]     noise;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;
   assign rsp_tdata  = {{(ign_pkg::RSP_DATA_W - ign_pkg::OUT_W){1'b0}}, noise};

   // Item decode.
   ign_front u_front (
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .cmd       (cmd)
   );

   // Queue between decode and execution.
   ign_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head       (head),
      .count      (q_count)
   );

   // Table update and noise pipeline.
   ign_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .take       (q_pop),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_noise  (noise),
      .stat       (stat)
   );

   // A load leaves a bubble behind it in the first stage.
   assert property (@(posedge clock) disable iff (reset)
      stat.load_take |=> !stat.s1_busy)
      else $error("sample entered right behind a table load");

   // The queue grows by one on a push without a pop.
   assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_pop) |=> (q_count == ign_pkg::QCNT_W'($past(q_count) + 1'b1)))
      else $error("queue count lost a push");

   // Nothing leaves an empty queue.
   assert property (@(posedge clock) disable iff (reset)
      (q_count == '0) |-> !q_pop)
      else $error("item taken from an empty queue");

endmodule
